### src/qdpr_pkg.sv
// Shared types and constants for the quantized dot product requantizer.
// Used by the front, the row queue, the back end and the top level.
// Has no dependencies.
package qdpr_pkg;

    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 31;
    localparam int LEN_CFG_W   = 13;
    localparam int ROW_W       = 12;
    localparam int ACC_W       = 32;
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = 2;
    localparam int QCNT_W      = 3;

    localparam logic [7:0] OUT_MAX = 8'd255;

    localparam logic [CFG_INDEX_W-1:0] REG_IN_LENGTH    = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_OUT_LENGTH   = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_INPUT_ZP     = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_WEIGHT_ZP    = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_OUTPUT_ZP    = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] REG_MULTIPLIER   = 3'd5;
    localparam logic [CFG_INDEX_W-1:0] REG_SHIFT        = 3'd6;
    localparam logic [CFG_INDEX_W-1:0] REG_BIAS_ENABLE  = 3'd7;

    typedef struct packed {
        logic [LEN_CFG_W-1:0] in_length;
        logic [LEN_CFG_W-1:0] out_length;
        logic [7:0]           input_zp;
        logic signed [7:0]    weight_zp;
        logic                 bias_enable;
    } front_cfg_t;

    typedef struct packed {
        logic [30:0] multiplier;
        logic [5:0]  shift;
        logic [7:0]  output_zp;
    } back_cfg_t;

    typedef struct packed {
        logic [ACC_W-1:0] acc;
        logic [ROW_W-1:0] row;
        logic             last;
    } row_entry_t;

endpackage

### src/qdpr_front.sv
// Front end: accepts activation/weight/bias items, runs the multiply-accumulate
// and the column and row counters, and emits one row entry at each row end.
// Depends on qdpr_pkg.
module qdpr_front import qdpr_pkg::*; #(
    parameter int MAX_LENGTH = 4096,
    parameter int MAX_ROWS   = 4096
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  front_cfg_t        cfg,
    input  logic              in_fire,
    input  logic [7:0]        activation,
    input  logic signed [7:0] weight,
    input  logic signed [31:0] bias,
    output logic              push,
    output row_entry_t        push_entry
);

    localparam int LEN_W = $clog2(MAX_LENGTH + 1);
    localparam int RW    = $clog2(MAX_ROWS + 1);

    logic [ACC_W-1:0] acc_reg, acc_next, acc_base;
    logic [LEN_W-1:0] col_reg, col_next, col_inc, n_len;
    logic [RW-1:0]    row_reg, row_next, row_inc, n_rows;
    logic signed [8:0]  da, dw;
    logic signed [17:0] prod;
    logic             row_end, last;

    always_comb begin
        if (cfg.in_length == '0) begin
            n_len = LEN_W'(1);
        end else if (32'(cfg.in_length) > MAX_LENGTH) begin
            n_len = LEN_W'(MAX_LENGTH);
        end else begin
            n_len = LEN_W'(cfg.in_length);
        end
        if (cfg.out_length == '0) begin
            n_rows = RW'(1);
        end else if (32'(cfg.out_length) > MAX_ROWS) begin
            n_rows = RW'(MAX_ROWS);
        end else begin
            n_rows = RW'(cfg.out_length);
        end
    end

    assign da   = $signed({1'b0, activation}) - $signed({1'b0, cfg.input_zp});
    assign dw   = 9'(weight) - 9'(cfg.weight_zp);
    assign prod = da * dw;

    always_comb begin
        if (col_reg == '0) begin
            acc_base = cfg.bias_enable ? bias : '0;
        end else begin
            acc_base = acc_reg;
        end
    end

    assign acc_next = acc_base + ACC_W'(prod);
    assign col_inc  = col_reg + LEN_W'(1);
    assign row_inc  = row_reg + RW'(1);
    assign row_end  = col_inc >= n_len;
    assign last     = row_inc >= n_rows;

    always_comb begin
        col_next = col_reg;
        row_next = row_reg;
        if (in_fire) begin
            col_next = row_end ? '0 : col_inc;
            if (row_end) begin
                row_next = last ? '0 : row_inc;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            acc_reg <= '0;
            col_reg <= '0;
            row_reg <= '0;
        end else begin
            if (in_fire) begin
                acc_reg <= acc_next;
            end
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

    assign push            = in_fire && row_end;
    assign push_entry.acc  = acc_next;
    assign push_entry.row  = ROW_W'(row_reg);
    assign push_entry.last = last;

    a_col_restart: assert property (@(posedge aclk) disable iff (!aresetn)
        push |=> col_reg == '0)
        else $error("column count did not restart after a row end");

endmodule

### src/qdpr_queue.sv
// Short queue of finished row sums between the front end and the back end.
// Depends on qdpr_pkg.
module qdpr_queue import qdpr_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       push,
    input  row_entry_t push_entry,
    input  logic       pop,
    output row_entry_t head,
    output logic       not_empty,
    output logic       full
);

    row_entry_t          slot_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]   wr_ptr_reg, rd_ptr_reg;
    logic [QCNT_W-1:0]   count_reg, count_next;

    assign head      = slot_reg[rd_ptr_reg];
    assign not_empty = count_reg != '0;
    assign full      = count_reg == QCNT_W'(QUEUE_DEPTH);

    always_comb begin
        count_next = count_reg;
        if (push && !pop) begin
            count_next = count_reg + QCNT_W'(1);
        end else if (pop && !push) begin
            count_next = count_reg - QCNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= push_entry;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + QPTR_W'(1);
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + QPTR_W'(1);
            end
            count_reg <= count_next;
        end
    end

    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        push |-> (!full || pop))
        else $error("row queue written while full");

    a_no_underflow: assert property (@(posedge aclk) disable iff (!aresetn)
        pop |-> not_empty)
        else $error("row queue read while empty");

endmodule

### src/qdpr_back.sv
// Back end: scales each row sum by the fixed-point multiplier, rounds half away
// from zero, adds the output zero point, clamps and holds the result for transfer.
// Depends on qdpr_pkg.
module qdpr_back import qdpr_pkg::*; (
    input  logic             aclk,
    input  logic             aresetn,
    input  back_cfg_t        cfg,
    input  logic             q_valid,
    input  row_entry_t       q_entry,
    output logic             pop,
    output logic             m_valid,
    input  logic             m_ready,
    output logic [7:0]       m_out_value,
    output logic [ROW_W-1:0] m_row_index,
    output logic             m_layer_last
);

    logic               p1_valid_reg, p2_valid_reg, out_valid_reg;
    logic signed [62:0] prod_reg;
    logic [61:0]        mag_reg;
    logic               neg_reg;
    logic [ROW_W-1:0]   p1_row_reg, p2_row_reg, out_row_reg;
    logic               p1_last_reg, p2_last_reg, out_last_reg;
    logic [7:0]         out_value_reg, value_next;

    logic               out_free, p2_free, p1_free, p1_adv, p2_adv;
    logic signed [63:0] prod_full;
    logic [62:0]        half, rounded, scaled;
    logic [8:0]         headroom;

    assign out_free = !out_valid_reg || m_ready;
    assign p2_adv   = p2_valid_reg && out_free;
    assign p2_free  = !p2_valid_reg || p2_adv;
    assign p1_adv   = p1_valid_reg && p2_free;
    assign p1_free  = !p1_valid_reg || p1_adv;
    assign pop      = q_valid && p1_free;

    assign prod_full = $signed(q_entry.acc) * $signed({1'b0, cfg.multiplier});

    always_comb begin
        if (cfg.shift == '0) begin
            half = '0;
        end else begin
            half = 63'(1) << (cfg.shift - 6'd1);
        end
    end

    assign rounded  = {1'b0, mag_reg} + half;
    assign scaled   = rounded >> cfg.shift;
    assign headroom = {1'b0, OUT_MAX} - {1'b0, cfg.output_zp};

    always_comb begin
        if (neg_reg) begin
            if (scaled > 63'(cfg.output_zp)) begin
                value_next = '0;
            end else begin
                value_next = cfg.output_zp - 8'(scaled);
            end
        end else begin
            if (scaled > 63'(headroom)) begin
                value_next = OUT_MAX;
            end else begin
                value_next = cfg.output_zp + 8'(scaled);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (pop) begin
            prod_reg    <= 63'(prod_full);
            p1_row_reg  <= q_entry.row;
            p1_last_reg <= q_entry.last;
        end
        if (p1_adv) begin
            neg_reg     <= prod_reg[62];
            mag_reg     <= prod_reg[62] ? 62'(-prod_reg) : 62'(prod_reg);
            p2_row_reg  <= p1_row_reg;
            p2_last_reg <= p1_last_reg;
        end
        if (p2_adv) begin
            out_value_reg <= value_next;
            out_row_reg   <= p2_row_reg;
            out_last_reg  <= p2_last_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p1_valid_reg  <= 1'b0;
            p2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (p1_free) begin
                p1_valid_reg <= pop;
            end
            if (p2_free) begin
                p2_valid_reg <= p1_adv;
            end
            if (out_free) begin
                out_valid_reg <= p2_adv;
            end
        end
    end

    assign m_valid      = out_valid_reg;
    assign m_out_value  = out_value_reg;
    assign m_row_index  = out_row_reg;
    assign m_layer_last = out_last_reg;

    a_p1_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (p1_valid_reg && !p2_free) |=> p1_valid_reg)
        else $error("product stage dropped a stalled row");

    a_p2_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (p2_valid_reg && !out_free) |=> (p2_valid_reg && $stable(mag_reg)))
        else $error("magnitude stage changed while stalled");

endmodule

### src/quantized_dot_product_requantize_top.sv
// Top level of the quantized dot product requantizer: configuration registers,
// front end, row queue and back end. Depends on qdpr_pkg and all qdpr modules.
//
// The block accepts one activation/weight/bias transfer in every clock cycle as
// long as its four-entry row queue has room; the front end's single 9x9
// multiply-accumulate sets that rate. Each row end puts the 32-bit sum into the
// queue, and the back end turns it into an output byte through three registered
// steps (32x31 product, magnitude, round/shift/clamp). The back end finishes one
// row per cycle while m_ready is high. Configuration is to be written only while
// the block is idle; the block itself does not enforce this.
module quantized_dot_product_requantize_top import qdpr_pkg::*; #(
    parameter int MAX_LENGTH = 4096,
    parameter int MAX_ROWS   = 4096
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   cfg_wr_en,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_wdata,
    input  logic                   s_valid,
    output logic                   s_ready,
    input  logic [7:0]             s_activation,
    input  logic signed [7:0]      s_weight,
    input  logic signed [31:0]     s_bias,
    output logic                   m_valid,
    input  logic                   m_ready,
    output logic [7:0]             m_out_value,
    output logic [ROW_W-1:0]       m_row_index,
    output logic                   m_layer_last
);

    front_cfg_t front_cfg_reg;
    back_cfg_t  back_cfg_reg;
    row_entry_t push_entry, head;
    logic       push, pop, q_valid, q_full, in_fire;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            front_cfg_reg.in_length   <= LEN_CFG_W'(1);
            front_cfg_reg.out_length  <= LEN_CFG_W'(1);
            front_cfg_reg.input_zp    <= '0;
            front_cfg_reg.weight_zp   <= '0;
            front_cfg_reg.bias_enable <= 1'b0;
            back_cfg_reg.multiplier   <= 31'h4000_0000;
            back_cfg_reg.shift        <= 6'd31;
            back_cfg_reg.output_zp    <= '0;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                REG_IN_LENGTH:   front_cfg_reg.in_length   <= cfg_wdata[LEN_CFG_W-1:0];
                REG_OUT_LENGTH:  front_cfg_reg.out_length  <= cfg_wdata[LEN_CFG_W-1:0];
                REG_INPUT_ZP:    front_cfg_reg.input_zp    <= cfg_wdata[7:0];
                REG_WEIGHT_ZP:   front_cfg_reg.weight_zp   <= cfg_wdata[7:0];
                REG_OUTPUT_ZP:   back_cfg_reg.output_zp    <= cfg_wdata[7:0];
                REG_MULTIPLIER:  back_cfg_reg.multiplier   <= cfg_wdata[30:0];
                REG_SHIFT:       back_cfg_reg.shift        <= cfg_wdata[5:0];
                REG_BIAS_ENABLE: front_cfg_reg.bias_enable <= cfg_wdata[0];
                default: begin
                end
            endcase
        end
    end

    assign s_ready = !q_full;
    assign in_fire = s_valid && s_ready;

    qdpr_front #(
        .MAX_LENGTH (MAX_LENGTH),
        .MAX_ROWS   (MAX_ROWS)
    ) u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg        (front_cfg_reg),
        .in_fire    (in_fire),
        .activation (s_activation),
        .weight     (s_weight),
        .bias       (s_bias),
        .push       (push),
        .push_entry (push_entry)
    );

    qdpr_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (push),
        .push_entry (push_entry),
        .pop        (pop),
        .head       (head),
        .not_empty  (q_valid),
        .full       (q_full)
    );

    qdpr_back u_back (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg          (back_cfg_reg),
        .q_valid      (q_valid),
        .q_entry      (head),
        .pop          (pop),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_out_value  (m_out_value),
        .m_row_index  (m_row_index),
        .m_layer_last (m_layer_last)
    );

endmodule

### tb/tb_top.sv
// Self-checking testbench for quantized_dot_product_requantize_top.
// It predicts each requantized row result and compares it with the block's output.
// Depends on qdpr_pkg and the RTL of the block.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import qdpr_pkg::*;

    localparam int MAX_LENGTH    = 4096;
    localparam int MAX_ROWS      = 4096;
    localparam int SETTLE_CYCLES = 16;
    localparam int N_DIR         = 41;

    typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_t;

    typedef struct packed {
        logic [7:0]       value;
        logic [ROW_W-1:0] row;
        logic             last;
    } result_t;

    localparam result_t NO_EXPECT = '0;

    typedef struct {
        bit                     is_cfg;
        logic [CFG_INDEX_W-1:0] idx;
        logic [CFG_DATA_W-1:0]  data;
        logic [7:0]             act;
        logic signed [7:0]      wt;
        logic signed [31:0]     bias;
        bit                     pin;
        result_t                want;
    } dir_row_t;

    logic                   aclk = 1'b0;
    logic                   aresetn = 1'b0;
    logic                   cfg_wr_en = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_wdata = '0;
    logic                   s_valid = 1'b0;
    logic                   s_ready;
    logic [7:0]             s_activation = '0;
    logic signed [7:0]      s_weight = '0;
    logic signed [31:0]     s_bias = '0;
    logic                   m_valid;
    logic                   m_ready = 1'b0;
    logic [7:0]             m_out_value;
    logic [ROW_W-1:0]       m_row_index;
    logic                   m_layer_last;

    bit      pin_valid = 1'b0;
    result_t pin_expect = '0;

    // Mirror of the configuration registers and of the block's row state.
    logic [12:0]       cfg_in_len = 13'd1;
    logic [12:0]       cfg_out_len = 13'd1;
    logic [7:0]        cfg_izp = '0;
    logic signed [7:0] cfg_wzp = '0;
    logic [7:0]        cfg_ozp = '0;
    logic [30:0]       cfg_mult = 31'h4000_0000;
    logic [5:0]        cfg_shift = 6'd31;
    logic              cfg_bias_en = 1'b0;
    logic [31:0]       acc_sum = '0;
    int unsigned       col_count = 0;
    int unsigned       row_count = 0;

    result_t pending_outputs [$];
    int      gap_pct = 0;
    int      stall_pct = 0;
    int      errors = 0;
    int      n_items = 0;
    int      n_results = 0;
    int      n_cfg_writes = 0;

    // With the reset setting every transfer ends a row and yields round(act * wt / 2), clamped to 0..255.
    dir_row_t dir_table [N_DIR] = '{
        '{1'b0, REG_IN_LENGTH, 31'd0, 8'd0, 8'sd0, 32'sh7FFF_FFFF, 1'b1, {8'd0, 12'd0, 1'b1}},
        '{1'b0, REG_IN_LENGTH, 31'd0, 8'd255, 8'sd127, 32'sh8000_0000, 1'b1,
          {8'd255, 12'd0, 1'b1}},
        '{1'b0, REG_IN_LENGTH, 31'd0, 8'd255, 8'sh80, 32'sd0, 1'b1, {8'd0, 12'd0, 1'b1}},
        '{1'b0, REG_IN_LENGTH, 31'd0, 8'd1, 8'sd1, 32'sd0, 1'b1, {8'd1, 12'd0, 1'b1}},
        '{1'b0, REG_IN_LENGTH, 31'd0, 8'd1, 8'shFF, 32'sd0, 1'b1, {8'd0, 12'd0, 1'b1}},
        '{1'b0, REG_IN_LENGTH, 31'd0, 8'd200, 8'sd1, 32'sd0, 1'b1, {8'd100, 12'd0, 1'b1}},
        '{1'b0, REG_IN_LENGTH, 31'd0, 8'd5, 8'sd1, 32'sd0, 1'b1, {8'd3, 12'd0, 1'b1}},
        '{1'b1, REG_BIAS_ENABLE, 31'd1, 8'd0, 8'sd0, 32'sd0, 1'b0, NO_EXPECT},
        '{1'b0, REG_IN_LENGTH, 31'd0, 8'd0, 8'sd0, 32'sd100, 1'b1, {8'd50, 12'd0, 1'b1}},
        '{1'b0, REG_IN_LENGTH, 31'd0, 8'd0, 8'sd0, 32'sh7FFF_FFFF, 1'b1,
          {8'd255, 12'd0, 1'b1}},
        '{1'b0, REG_IN_LENGTH, 31'd0, 8'd255, 8'sd127, 32'sh8000_0000, 1'b1,
          {8'd0, 12'd0, 1'b1}},
        '{1'b1, REG_OUTPUT_ZP, 31'd255, 8'd0, 8'sd0, 32'sd0, 1'b0, NO_EXPECT},
        '{1'b0, REG_IN_LENGTH, 31'd0, 8'd0, 8'sd0, -32'sd200, 1'b1, {8'd155, 12'd0, 1'b1}},
        '{1'b0, REG_IN_LENGTH, 31'd0, 8'd0, 8'sd0, -32'sd201, 1'b1, {8'd154, 12'd0, 1'b1}},
        '{1'b1, REG_WEIGHT_ZP, 31'h80, 8'd0, 8'sd0, 32'sd0, 1'b0, NO_EXPECT},
        '{1'b1, REG_INPUT_ZP, 31'd255, 8'd0, 8'sd0, 32'sd0, 1'b0, NO_EXPECT},
        '{1'b1, REG_MULTIPLIER, 31'h7FFF_FFFF, 8'd0, 8'sd0, 32'sd0, 1'b0, NO_EXPECT},
        '{1'b1, REG_SHIFT, 31'd63, 8'd0, 8'sd0, 32'sd0, 1'b0, NO_EXPECT},
        '{1'b1, REG_IN_LENGTH, 31'd0, 8'd0, 8'sd0, 32'sd0, 1'b0, NO_EXPECT},
        '{1'b1, REG_OUT_LENGTH, 31'd0, 8'd0, 8'sd0, 32'sd0, 1'b0, NO_EXPECT},
        '{1'b0, REG_IN_LENGTH, 31'd0, 8'd0, 8'sd127, 32'sd1, 1'b0, NO_EXPECT},
        '{1'b0, REG_IN_LENGTH, 31'd0, 8'd255, 8'sh80, 32'sh8000_0000, 1'b0, NO_EXPECT},
        '{1'b1, REG_SHIFT, 31'd0, 8'd0, 8'sd0, 32'sd0, 1'b0, NO_EXPECT},
        '{1'b1, REG_MULTIPLIER, 31'd1, 8'd0, 8'sd0, 32'sd0, 1'b0, NO_EXPECT},
        '{1'b1, REG_OUTPUT_ZP, 31'd0, 8'd0, 8'sd0, 32'sd0, 1'b0, NO_EXPECT},
        '{1'b1, REG_INPUT_ZP, 31'd0, 8'd0, 8'sd0, 32'sd0, 1'b0, NO_EXPECT},
        '{1'b1, REG_WEIGHT_ZP, 31'd0, 8'd0, 8'sd0, 32'sd0, 1'b0, NO_EXPECT},
        '{1'b1, REG_BIAS_ENABLE, 31'd0, 8'd0, 8'sd0, 32'sd0, 1'b0, NO_EXPECT},
        '{1'b1, REG_IN_LENGTH, 31'd3, 8'd0, 8'sd0, 32'sd0, 1'b0, NO_EXPECT},
        '{1'b1, REG_OUT_LENGTH, 31'd2, 8'd0, 8'sd0, 32'sd0, 1'b0, NO_EXPECT},
        '{1'b0, REG_IN_LENGTH, 31'd0, 8'd3, 8'sd4, 32'sd9, 1'b0, NO_EXPECT},
        '{1'b0, REG_IN_LENGTH, 31'd0, 8'd10, 8'sd7, 32'sd0, 1'b0, NO_EXPECT},
        '{1'b0, REG_IN_LENGTH, 31'd0, 8'd2, 8'shF0, 32'sd0, 1'b0, NO_EXPECT},
        '{1'b0, REG_IN_LENGTH, 31'd0, 8'd1, 8'sd50, 32'sd0, 1'b0, NO_EXPECT},
        '{1'b0, REG_IN_LENGTH, 31'd0, 8'd4, 8'sd30, 32'sd0, 1'b0, NO_EXPECT},
        '{1'b0, REG_IN_LENGTH, 31'd0, 8'd0, 8'sd1, 32'sd0, 1'b0, NO_EXPECT},
        '{1'b1, REG_IN_LENGTH, 31'd3, 8'd0, 8'sd0, 32'sd0, 1'b0, NO_EXPECT},
        '{1'b0, REG_IN_LENGTH, 31'd0, 8'd9, 8'sd9, 32'sd0, 1'b0, NO_EXPECT},
        '{1'b0, REG_IN_LENGTH, 31'd0, 8'd8, 8'sd2, 32'sd0, 1'b0, NO_EXPECT},
        '{1'b1, REG_IN_LENGTH, 31'd1, 8'd0, 8'sd0, 32'sd0, 1'b0, NO_EXPECT},
        '{1'b0, REG_IN_LENGTH, 31'd0, 8'd6, 8'sd5, 32'sd0, 1'b0, NO_EXPECT}
    };

    quantized_dot_product_requantize_top #(
        .MAX_LENGTH(MAX_LENGTH),
        .MAX_ROWS  (MAX_ROWS)
    ) u_dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_wdata   (cfg_wdata),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_activation(s_activation),
        .s_weight    (s_weight),
        .s_bias      (s_bias),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_out_value (m_out_value),
        .m_row_index (m_row_index),
        .m_layer_last(m_layer_last)
    );

    always #2 aclk = ~aclk;

    always @(posedge aclk) begin
        m_ready <= ($urandom_range(0, 99) >= stall_pct);
    end

    function automatic bit requant_row_step(input logic [7:0] act, input logic signed [7:0] wt,
                                            input logic signed [31:0] bias,
                                            output result_t res);
        int          da;
        int          dw;
        int unsigned n_cols;
        int unsigned n_rows;
        longint      prod;
        longint      y;
        logic [63:0] mag;
        logic [63:0] rnd;
        bit          neg;
        res = NO_EXPECT;
        da = int'(act) - int'(cfg_izp);
        dw = int'(wt) - int'(cfg_wzp);
        n_cols = (cfg_in_len == 0) ? 1 : (cfg_in_len > MAX_LENGTH) ? MAX_LENGTH : cfg_in_len;
        n_rows = (cfg_out_len == 0) ? 1 : (cfg_out_len > MAX_ROWS) ? MAX_ROWS : cfg_out_len;
        if (col_count == 0) begin
            acc_sum = cfg_bias_en ? bias : '0;
        end
        acc_sum = acc_sum + 32'(da * dw);
        col_count++;
        if (col_count < n_cols) begin
            return 1'b0;
        end
        col_count = 0;
        prod = longint'($signed(acc_sum)) * longint'({1'b0, cfg_mult});
        neg = (prod < 0);
        mag = neg ? 64'(-prod) : 64'(prod);
        if (cfg_shift == 0) begin
            rnd = mag;
        end else begin
            rnd = (mag + (64'd1 << (cfg_shift - 1))) >> cfg_shift;
        end
        y = neg ? -longint'(rnd) : longint'(rnd);
        y += longint'(cfg_ozp);
        res.value = (y < 0) ? 8'd0 : (y > 255) ? OUT_MAX : 8'(y);
        res.row = ROW_W'(row_count);
        res.last = (row_count + 1 >= n_rows);
        row_count = res.last ? 0 : row_count + 1;
        return 1'b1;
    endfunction

    always @(posedge aclk) begin : scoreboard
        result_t predicted;
        result_t got;
        result_t want;
        bit      produced;
        if (aresetn) begin
            if (s_valid && s_ready) begin
                produced = requant_row_step(s_activation, s_weight, s_bias, predicted);
                if (pin_valid) begin
                    pending_outputs.push_back(pin_expect);
                end else if (produced) begin
                    pending_outputs.push_back(predicted);
                end
            end
            if (m_valid && m_ready) begin
                got = {m_out_value, m_row_index, m_layer_last};
                n_results++;
                if (pending_outputs.size() == 0) begin
                    errors++;
                    $display("%0t: unexpected result, out_value %0d row_index %0d layer_last %0b",
                             $time, got.value, got.row, got.last);
                end else begin
                    want = pending_outputs.pop_front();
                    if (got.value !== want.value) begin
                        errors++;
                        $display("%0t: out_value expected %0d, got %0d",
                                 $time, want.value, got.value);
                    end
                    if (got.row !== want.row) begin
                        errors++;
                        $display("%0t: row_index expected %0d, got %0d",
                                 $time, want.row, got.row);
                    end
                    if (got.last !== want.last) begin
                        errors++;
                        $display("%0t: layer_last expected %0b, got %0b",
                                 $time, want.last, got.last);
                    end
                end
            end
        end
    end

    task automatic cfg_write(input logic [CFG_INDEX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= data;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        case (idx)
            REG_IN_LENGTH:   cfg_in_len = data[12:0];
            REG_OUT_LENGTH:  cfg_out_len = data[12:0];
            REG_INPUT_ZP:    cfg_izp = data[7:0];
            REG_WEIGHT_ZP:   cfg_wzp = data[7:0];
            REG_OUTPUT_ZP:   cfg_ozp = data[7:0];
            REG_MULTIPLIER:  cfg_mult = data[30:0];
            REG_SHIFT:       cfg_shift = data[5:0];
            REG_BIAS_ENABLE: cfg_bias_en = data[0];
            default: ;
        endcase
        n_cfg_writes++;
        @(posedge aclk);
    endtask

    task automatic push_item(input logic [7:0] act, input logic signed [7:0] wt,
                             input logic signed [31:0] bias, input bit pin,
                             input result_t pin_res);
        if ($urandom_range(0, 99) < gap_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
            while ($urandom_range(0, 99) < gap_pct) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_activation <= act;
        s_weight <= wt;
        s_bias <= bias;
        pin_valid <= pin;
        pin_expect <= pin_res;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        n_items++;
    endtask

    task automatic wait_idle();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending_outputs.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic set_idling(input idle_mode_t mode);
        case (mode)
            IDLE_SENDER:   begin gap_pct = 85; stall_pct = 0;  end
            IDLE_RECEIVER: begin gap_pct = 0;  stall_pct = 85; end
            IDLE_BOTH:     begin gap_pct = 23; stall_pct = 23; end
            default:       begin gap_pct = 0;  stall_pct = 0;  end
        endcase
    endtask

    // A layer setting of 0 holds the low extremes, 1 the high ones with random in_len, others random.
    task automatic program_layer(input int sel);
        logic [12:0] in_len;
        logic [12:0] out_len;
        logic [7:0]  izp;
        logic [7:0]  wzp;
        logic [7:0]  ozp;
        logic [30:0] mult;
        logic [5:0]  shift;
        logic        ben;
        int          pick;
        in_len = 13'($urandom_range(0, 12));
        out_len = ($urandom_range(0, 4) == 0) ? 13'd8191 : 13'($urandom_range(0, 5));
        izp = 8'($urandom);
        wzp = 8'($urandom);
        ozp = 8'($urandom);
        ben = 1'($urandom);
        pick = $urandom_range(0, 9);
        if (pick == 0) begin
            shift = 6'd0;
            mult = 31'($urandom_range(0, 1));
        end else if (pick == 1) begin
            shift = 6'd63;
            mult = 31'h7FFF_FFFF;
        end else begin
            shift = 6'($urandom_range(32, 44));
            mult = 31'($urandom_range(32'h4000_0000, 32'h7FFF_FFFF));
        end
        if (sel == 0) begin
            in_len = 13'd1;
            out_len = 13'd1;
            izp = 8'd0;
            wzp = 8'h80;
            ozp = 8'd0;
            mult = 31'd0;
            shift = 6'd0;
            ben = 1'b0;
        end else if (sel == 1) begin
            out_len = 13'd8191;
            izp = 8'd255;
            wzp = 8'h7F;
            ozp = 8'd255;
            mult = 31'h7FFF_FFFF;
            shift = 6'd62;
            ben = 1'b1;
        end
        cfg_write(REG_IN_LENGTH, CFG_DATA_W'(in_len));
        cfg_write(REG_OUT_LENGTH, CFG_DATA_W'(out_len));
        cfg_write(REG_INPUT_ZP, CFG_DATA_W'(izp));
        cfg_write(REG_WEIGHT_ZP, CFG_DATA_W'(wzp));
        cfg_write(REG_OUTPUT_ZP, CFG_DATA_W'(ozp));
        cfg_write(REG_MULTIPLIER, mult);
        cfg_write(REG_SHIFT, CFG_DATA_W'(shift));
        cfg_write(REG_BIAS_ENABLE, CFG_DATA_W'(ben));
    endtask

    task automatic run_items(input int count);
        logic [7:0]         act;
        logic signed [7:0]  wt;
        logic signed [31:0] bias;
        for (int i = 0; i < count; i++) begin
            act = ($urandom_range(0, 7) == 0) ? ($urandom_range(0, 1) ? 8'd255 : 8'd0)
                                              : 8'($urandom);
            wt = ($urandom_range(0, 7) == 0) ? ($urandom_range(0, 1) ? 8'sh7F : 8'sh80)
                                             : 8'($urandom);
            bias = ($urandom_range(0, 3) == 0) ? 32'($urandom)
                                               : 32'(int'($urandom_range(0, 131071)) - 65536);
            push_item(act, wt, bias, 1'b0, NO_EXPECT);
        end
        wait_idle();
    endtask

    initial begin
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        set_idling(IDLE_NONE);
        for (int r = 0; r < N_DIR; r++) begin
            if (dir_table[r].is_cfg) begin
                wait_idle();
                cfg_write(dir_table[r].idx, dir_table[r].data);
            end else begin
                push_item(dir_table[r].act, dir_table[r].wt, dir_table[r].bias,
                          dir_table[r].pin, dir_table[r].want);
            end
        end
        wait_idle();
        for (int ph = 0; ph < 8; ph++) begin
            program_layer(ph);
            set_idling(idle_mode_t'(ph % 4));
            run_items(100);
        end
        $display("Sent %0d input transfers across %0d register writes and checked %0d results.",
                 n_items, n_cfg_writes, n_results);
        $display("Lengths, zero points, rounding, bias and saturation extremes were exercised.");
        if (errors == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

    initial begin
        #2_000_000;
        $display("Timed out with %0d results outstanding.", pending_outputs.size());
        $display("CHECK FAILED");
        $finish;
    end

endmodule
